// ===== hw/rtl/pds_pkg.sv =====
// Shared types and constants of the PLL divider search block.
// No dependencies; used by every module under hw/rtl.
package pds_pkg;

  localparam int REF_W  = 16;
  localparam int FREQ_W = 24;
  localparam int FB_W   = 9;
  localparam int PD_W   = 3;
  localparam int DVS_W  = 2 * PD_W;

  localparam int FBDIV_MIN_DEF   = 16;
  localparam int FBDIV_MAX_DEF   = 320;
  localparam int POSTDIV_MAX_DEF = 7;

  localparam logic [FREQ_W-1:0] ERR_LIMIT = FREQ_W'(100000);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_REF_KHZ   = 2'd0;
  localparam logic [1:0] REG_VCO_MIN   = 2'd1;
  localparam logic [1:0] REG_VCO_MAX   = 2'd2;
  localparam logic [1:0] REG_PREFER_LO = 2'd3;

  typedef struct packed {
    logic [REF_W-1:0]  ref_khz;
    logic [FREQ_W-1:0] vco_min_khz;
    logic [FREQ_W-1:0] vco_max_khz;
    logic              prefer_low_vco;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic              exact;
    logic [FREQ_W-1:0] khz;
    logic [FREQ_W-1:0] vco_khz;
    logic [FB_W-1:0]   fb_div;
    logic [PD_W-1:0]   post_div1;
    logic [PD_W-1:0]   post_div2;
  } result_t;

endpackage

// ===== hw/rtl/pds_cfg_regs.sv =====
// APB-style configuration registers of the PLL divider search block.
// Depends on pds_pkg.
module pds_cfg_regs
  import pds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o,
  output cfg_t              cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign reg_idx  = paddr_i[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_khz        <= REF_W'(12000);
      cfg_q.vco_min_khz    <= FREQ_W'(400000);
      cfg_q.vco_max_khz    <= FREQ_W'(1600000);
      cfg_q.prefer_low_vco <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_REF_KHZ:   cfg_q.ref_khz        <= pwdata_i[REF_W-1:0];
        REG_VCO_MIN:   cfg_q.vco_min_khz    <= pwdata_i[FREQ_W-1:0];
        REG_VCO_MAX:   cfg_q.vco_max_khz    <= pwdata_i[FREQ_W-1:0];
        REG_PREFER_LO: cfg_q.prefer_low_vco <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (reg_idx)
      REG_REF_KHZ:   prdata_o = APB_DW'(cfg_q.ref_khz);
      REG_VCO_MIN:   prdata_o = APB_DW'(cfg_q.vco_min_khz);
      REG_VCO_MAX:   prdata_o = APB_DW'(cfg_q.vco_max_khz);
      REG_PREFER_LO: prdata_o = APB_DW'(cfg_q.prefer_low_vco);
      default:       prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/pds_div.sv =====
// Bit-serial restoring divider: VCO frequency by the post divider product.
// One quotient bit per cycle. Depends on pds_pkg.
module pds_div
  import pds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FREQ_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [FREQ_W-1:0] quot_o,
  output logic              rem_zero_o
);

  localparam int CNT_W = $clog2(FREQ_W);

  logic [FREQ_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DVS_W:0]    shifted, diff;
  logic              ge;

  assign shifted = {rem_q, quo_q[FREQ_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign rem_d   = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  assign quo_d   = {quo_q[FREQ_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FREQ_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quot_o     = quo_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

// ===== hw/rtl/pds_search.sv =====
// Search sequencer: walks feedback and post dividers, keeps the best candidate.
// Depends on pds_pkg and pds_div.
module pds_search
  import pds_pkg::*;
#(
  parameter int FBDIV_MIN   = FBDIV_MIN_DEF,
  parameter int FBDIV_MAX   = FBDIV_MAX_DEF,
  parameter int POSTDIV_MAX = POSTDIV_MAX_DEF
)(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              start_i,
  input  logic [FREQ_W-1:0] req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  input  logic              res_take_i,
  output result_t           res_o
);

  localparam int FBW  = $clog2(FBDIV_MAX + 1);
  localparam int VCOW = FBW + REF_W;

  typedef enum logic [2:0] {
    S_IDLE, S_VCO, S_CHECK, S_DIV_GO, S_DIV_WAIT, S_EVAL, S_NEXT_FB, S_FINISH
  } state_e;

  state_e            state_q;
  logic [FBW-1:0]    fb_q, fb_last;
  logic [VCOW-1:0]   vco_q;
  logic [PD_W-1:0]   p1_q, p2_q;
  logic [FREQ_W-1:0] req_q, best_err_q, err;
  result_t           best_q;
  logic              in_window;
  logic [DVS_W-1:0]  divisor;
  logic              div_done, rem_zero;
  logic [FREQ_W-1:0] quot;
  logic [FBW+FB_W-1:0] fb_ext;

  assign fb_last   = cfg_i.prefer_low_vco ? FBW'(FBDIV_MAX) : FBW'(FBDIV_MIN);
  assign in_window = (vco_q >= VCOW'(cfg_i.vco_min_khz)) &&
                     (vco_q <= VCOW'(cfg_i.vco_max_khz));
  assign divisor   = DVS_W'({{PD_W{1'b0}}, p1_q} * {{PD_W{1'b0}}, p2_q});
  assign err       = (quot >= req_q) ? (quot - req_q) : (req_q - quot);
  assign fb_ext    = {{FB_W{1'b0}}, fb_q};

  pds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIV_GO),
    .dividend_i (vco_q[FREQ_W-1:0]),  // a VCO inside the window fits 24 bits
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_zero_o (rem_zero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fb_q       <= '0;
      vco_q      <= '0;
      p1_q       <= '0;
      p2_q       <= '0;
      req_q      <= '0;
      best_err_q <= '0;
      best_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q    <= S_VCO;
            req_q      <= req_i;
            fb_q       <= cfg_i.prefer_low_vco ? FBW'(FBDIV_MIN) : FBW'(FBDIV_MAX);
            best_err_q <= ERR_LIMIT;
            best_q     <= '0;
          end
        end
        S_VCO: begin
          vco_q   <= VCOW'(fb_q) * VCOW'(cfg_i.ref_khz);
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          p1_q    <= PD_W'(POSTDIV_MAX);
          p2_q    <= PD_W'(POSTDIV_MAX);
          state_q <= in_window ? S_DIV_GO : S_NEXT_FB;
        end
        S_DIV_GO:   state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) state_q <= S_EVAL;
        end
        S_EVAL: begin
          // strict compare: the first candidate visited wins a tie
          if (err < best_err_q) begin
            best_err_q        <= err;
            best_q.found      <= 1'b1;
            best_q.exact      <= (quot == req_q) && rem_zero;
            best_q.khz        <= quot;
            best_q.vco_khz    <= vco_q[FREQ_W-1:0];
            best_q.fb_div     <= fb_ext[FB_W-1:0];
            best_q.post_div1  <= p1_q;
            best_q.post_div2  <= p2_q;
          end
          if (p2_q > PD_W'(1)) begin
            p2_q    <= p2_q - 1'b1;
            state_q <= S_DIV_GO;
          end else if (p1_q > PD_W'(1)) begin
            p1_q    <= p1_q - 1'b1;
            p2_q    <= p1_q - 1'b1;
            state_q <= S_DIV_GO;
          end else begin
            state_q <= S_NEXT_FB;
          end
        end
        S_NEXT_FB: begin
          if (fb_q == fb_last) begin
            state_q <= S_FINISH;
          end else begin
            fb_q    <= cfg_i.prefer_low_vco ? fb_q + 1'b1 : fb_q - 1'b1;
            state_q <= S_VCO;
          end
        end
        S_FINISH: begin
          if (res_take_i) state_q <= S_IDLE;
        end
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FINISH);
  assign res_o       = best_q;

endmodule

// ===== hw/rtl/pll_divider_search_core.sv =====
// Top level of the PLL divider search block: config port, sequencer, result register.
// Depends on pds_pkg, pds_cfg_regs and pds_search.
//
//  channel   signals                          direction
//  -------   -------------------------------  ---------
//  input     in_valid_i, in_stall_o, req_khz_i          in
//  result    out_valid_o, out_stall_i, found_o .. post_div2_o  out
//  config    psel_i .. pwdata_i, prdata_o, pready_o     APB
//
// One item: per candidate a divider start, the bit-serial divide, its done and a compare;
// 28 candidates per in-window VCO; each feedback divider also passes through the VCO,
// check and next-divider states.
// in_stall_o is high from acceptance until the result enters the output
// register; a stalled result holds there while the next item is accepted.
// Reset restores the register defaults and clears all valids.
module pll_divider_search_core
  import pds_pkg::*;
#(
  parameter int FBDIV_MIN   = FBDIV_MIN_DEF,
  parameter int FBDIV_MAX   = FBDIV_MAX_DEF,
  parameter int POSTDIV_MAX = POSTDIV_MAX_DEF
)(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FREQ_W-1:0] req_khz_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              found_o,
  output logic              exact_o,
  output logic [FREQ_W-1:0] out_khz_o,
  output logic [FREQ_W-1:0] out_vco_khz_o,
  output logic [FB_W-1:0]   feedback_div_o,
  output logic [PD_W-1:0]   post_div1_o,
  output logic [PD_W-1:0]   post_div2_o
);

  cfg_t    cfg;
  result_t res, out_q;
  logic    busy, res_valid, res_take, out_valid_q;

  pds_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  pds_search #(
    .FBDIV_MIN   (FBDIV_MIN),
    .FBDIV_MAX   (FBDIV_MAX),
    .POSTDIV_MAX (POSTDIV_MAX)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (in_valid_i & ~busy),
    .req_i       (req_khz_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // result register frees when empty or drained this cycle
  assign res_take = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) out_q <= res;
  end

  assign in_stall_o     = busy;
  assign out_valid_o    = out_valid_q;
  assign found_o        = out_q.found;
  assign exact_o        = out_q.exact;
  assign out_khz_o      = out_q.khz;
  assign out_vco_khz_o  = out_q.vco_khz;
  assign feedback_div_o = out_q.fb_div;
  assign post_div1_o    = out_q.post_div1;
  assign post_div2_o    = out_q.post_div2;

endmodule

// ===== bench/pll_divider_search_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for pll_divider_search_core: directed and random frequency requests,
// each result checked against an in-bench divider search. Needs pds_pkg and the RTL.
module pll_divider_search_core_tb;
  import pds_pkg::*;

  localparam int     CLK_PERIOD   = 12;
  localparam int     RESET_CYCLES = 6;
  localparam int     TAIL_CYCLES  = 5000;
  localparam int     HOLD_CYCLES  = 6000;
  localparam int     PRINT_MAX    = 100;
  localparam longint TIMEOUT_NS   = 64'd60_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel_i;
  logic              penable_i;
  logic              pwrite_i;
  logic [APB_AW-1:0] paddr_i;
  logic [APB_DW-1:0] pwdata_i;
  logic [APB_DW-1:0] prdata_o;
  logic              pready_o;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [FREQ_W-1:0] req_khz_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              found_o;
  logic              exact_o;
  logic [FREQ_W-1:0] out_khz_o;
  logic [FREQ_W-1:0] out_vco_khz_o;
  logic [FB_W-1:0]   feedback_div_o;
  logic [PD_W-1:0]   post_div1_o;
  logic [PD_W-1:0]   post_div2_o;

  typedef struct packed {
    logic [FREQ_W-1:0] req;
    result_t           best;
  } pll_pick_t;

  pll_pick_t pll_pick_q[$];
  cfg_t      model_cfg;
  bit        idle_en;
  int        rx_hold;
  int        rx_wait;
  int        win_fb_lo;
  int        win_fb_hi;
  int        n_errors;
  int        n_sent;
  int        n_checked;
  int        n_found;
  int        n_exact;
  int        n_settings;

  pll_divider_search_core u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned tag,
                                 input longint unsigned got, input longint unsigned want);
    n_errors++;
    if (n_errors <= PRINT_MAX)
      $display("MISMATCH %s @ %0d: got %0d, expected %0d", what, tag, got, want);
  endtask

  // Full search over feedback and post dividers, first best candidate wins.
  function automatic result_t search_pll_settings(input logic [FREQ_W-1:0] req);
    result_t           best;
    longint unsigned   best_err;
    longint unsigned   vco;
    longint unsigned   khz;
    longint unsigned   err;
    longint unsigned   back;
    int                fb;
    best     = '0;
    best_err = ERR_LIMIT;
    for (int n = 0; n <= FBDIV_MAX_DEF - FBDIV_MIN_DEF; n++) begin
      fb  = model_cfg.prefer_low_vco ? FBDIV_MIN_DEF + n : FBDIV_MAX_DEF - n;
      vco = longint'(fb) * model_cfg.ref_khz;
      if (vco >= model_cfg.vco_min_khz && vco <= model_cfg.vco_max_khz) begin
        for (int p1 = POSTDIV_MAX_DEF; p1 >= 1; p1--) begin
          for (int p2 = p1; p2 >= 1; p2--) begin
            khz = vco / longint'(p1 * p2);
            err = (khz >= req) ? khz - req : req - khz;
            if (err < best_err) begin
              best_err       = err;
              best.found     = 1'b1;
              best.khz       = khz[FREQ_W-1:0];
              best.vco_khz   = vco[FREQ_W-1:0];
              best.fb_div    = FB_W'(fb);
              best.post_div1 = PD_W'(p1);
              best.post_div2 = PD_W'(p2);
            end
          end
        end
      end
    end
    back = best.khz;
    back = back * best.post_div1 * best.post_div2;
    best.exact = best.found && (best.khz == req) && (back == best.vco_khz);
    return best;
  endfunction

  function automatic logic [APB_DW-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_REF_KHZ:   return APB_DW'(model_cfg.ref_khz);
      REG_VCO_MIN:   return APB_DW'(model_cfg.vco_min_khz);
      REG_VCO_MAX:   return APB_DW'(model_cfg.vco_max_khz);
      REG_PREFER_LO: return APB_DW'(model_cfg.prefer_low_vco);
      default:       return '0;
    endcase
  endfunction

  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= APB_AW'({idx, 2'b00});
    pwdata_i  <= wdata;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    rdata = prdata_o;
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx)) report_mismatch("register readback", idx, rd, reg_value(idx));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] unused;
    apb_xfer(1'b1, idx, value, unused);
    case (idx)
      REG_REF_KHZ:   model_cfg.ref_khz        = value[REF_W-1:0];
      REG_VCO_MIN:   model_cfg.vco_min_khz    = value[FREQ_W-1:0];
      REG_VCO_MAX:   model_cfg.vco_max_khz    = value[FREQ_W-1:0];
      REG_PREFER_LO: model_cfg.prefer_low_vco = value[0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pll_pick_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_req(input logic [FREQ_W-1:0] req);
    int        gap;
    pll_pick_t pick;
    gap = idle_en ? $urandom_range(3, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_khz_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pick.req  = req;
    pick.best = search_pll_settings(req);
    pll_pick_q.push_back(pick);
    n_sent++;
  endtask

  // Block is idle once every result is back; each item yields exactly one result.
  task automatic set_pll_config(input logic [APB_DW-1:0] ref_val, lo_val, hi_val, prefer_val);
    longint unsigned vco;
    stop_sending();
    wait_drained();
    write_reg(REG_REF_KHZ, ref_val);
    write_reg(REG_VCO_MIN, lo_val);
    write_reg(REG_VCO_MAX, hi_val);
    write_reg(REG_PREFER_LO, prefer_val);
    n_settings++;
    win_fb_lo = FBDIV_MAX_DEF + 1;
    win_fb_hi = 0;
    for (int fb = FBDIV_MIN_DEF; fb <= FBDIV_MAX_DEF; fb++) begin
      vco = longint'(fb) * model_cfg.ref_khz;
      if (vco >= model_cfg.vco_min_khz && vco <= model_cfg.vco_max_khz) begin
        if (fb < win_fb_lo) win_fb_lo = fb;
        win_fb_hi = fb;
      end
    end
  endtask

  // Mostly requests near a reachable output, some near the error limit, some noise.
  function automatic logic [FREQ_W-1:0] random_req();
    longint unsigned vco;
    longint unsigned khz;
    int              p1;
    int              p2;
    if (win_fb_lo > win_fb_hi) return FREQ_W'($urandom);
    vco = longint'($urandom_range(win_fb_hi, win_fb_lo)) * model_cfg.ref_khz;
    p1  = $urandom_range(POSTDIV_MAX_DEF, 1);
    p2  = $urandom_range(p1, 1);
    khz = vco / longint'(p1 * p2);
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: if (khz > 0) khz = khz - 1 + $urandom_range(2, 0);
      5: begin
        if ($urandom_range(1, 0) && khz > ERR_LIMIT) khz = khz - ERR_LIMIT - 1 + $urandom_range(2, 0);
        else khz = khz + ERR_LIMIT - 1 + $urandom_range(2, 0);
      end
      6, 7: khz = $urandom_range(vco, 0);
      default: khz = $urandom;
    endcase
    return khz[FREQ_W-1:0];
  endfunction

  // Narrow VCO window around a few feedback dividers keeps each search short.
  task automatic pick_random_setting();
    int              fb0;
    int              span;
    int              ref_max;
    longint unsigned refv;
    longint unsigned lo;
    longint unsigned hi;
    fb0     = $urandom_range(FBDIV_MAX_DEF, FBDIV_MIN_DEF);
    span    = $urandom_range(3, 0);
    ref_max = 16777215 / (fb0 + span);
    if (ref_max > 65535) ref_max = 65535;
    refv = $urandom_range(ref_max, 1);
    lo   = refv * fb0 - $urandom_range(refv - 1, 0);
    hi   = refv * (fb0 + span) + $urandom_range(refv - 1, 0);
    if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
    set_pll_config(APB_DW'(refv), APB_DW'(lo), APB_DW'(hi), APB_DW'($urandom_range(1, 0)));
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_result
    pll_pick_t pick;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pll_pick_q.size() == 0) begin
        report_mismatch("result with no request pending", 0, out_khz_o, 0);
      end else begin
        pick = pll_pick_q.pop_front();
        n_checked++;
        if (pick.best.found) n_found++;
        if (pick.best.exact) n_exact++;
        if (found_o !== pick.best.found)
          report_mismatch("found", pick.req, found_o, pick.best.found);
        if (exact_o !== pick.best.exact)
          report_mismatch("exact", pick.req, exact_o, pick.best.exact);
        if (out_khz_o !== pick.best.khz)
          report_mismatch("out_khz", pick.req, out_khz_o, pick.best.khz);
        if (out_vco_khz_o !== pick.best.vco_khz)
          report_mismatch("out_vco_khz", pick.req, out_vco_khz_o, pick.best.vco_khz);
        if (feedback_div_o !== pick.best.fb_div)
          report_mismatch("feedback_div", pick.req, feedback_div_o, pick.best.fb_div);
        if (post_div1_o !== pick.best.post_div1)
          report_mismatch("post_div1", pick.req, post_div1_o, pick.best.post_div1);
        if (post_div2_o !== pick.best.post_div2)
          report_mismatch("post_div2", pick.req, post_div2_o, pick.best.post_div2);
      end
    end
  end

  // Result side: random stall per item, plus long hold-offs on request.
  initial begin
    out_stall_i = 1'b0;
    rx_wait     = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) rx_wait = idle_en ? $urandom_range(3, 0) : 0;
      if (rx_hold > 0) begin
        out_stall_i <= 1'b1;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        if (out_valid_o) rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_reset_defaults();
    check_reg(REG_REF_KHZ);
    check_reg(REG_VCO_MIN);
    check_reg(REG_VCO_MAX);
    check_reg(REG_PREFER_LO);
    // one full-window search at reset settings
    send_req(24'd125000);
    stop_sending();
  endtask

  task automatic test_register_masking();
    // upper bits must be dropped: leaves ref 12000, window 1200000..1200000
    set_pll_config(32'hABCD_2EE0, 32'hFF12_4F80, 32'h5A12_4F80, 32'hFFFF_FFFE);
  endtask

  task automatic test_request_extremes();
    send_req(24'd0);
    send_req(24'hFFFFFF);
    send_req(24'd1200000);
    send_req(24'd600000);
    send_req(24'd24489);    // truncated output matches, but does not divide the VCO
    send_req(24'd1300000);  // error equals the limit
    send_req(24'd1299999);
    stop_sending();
  endtask

  task automatic test_empty_window();
    set_pll_config(12000, 1200001, 1211999, 0);
    send_req(24'd1200000);
    set_pll_config(12000, 1600000, 400000, 1);
    send_req(24'd500000);
    stop_sending();
  endtask

  task automatic test_zero_reference();
    set_pll_config(0, 1, 24'hFFFFFF, 0);
    send_req(24'd0);
    set_pll_config(1, 0, 16, 0);
    send_req(24'd0);
    send_req(24'd16);
    // every divider qualifies with a zero VCO
    set_pll_config(0, 0, 0, 1);
    send_req(24'd0);
    stop_sending();
  endtask

  task automatic test_search_direction();
    for (int dir = 0; dir < 2; dir++) begin
      set_pll_config(12000, 1188000, 1212000, dir);
      send_req(24'd400000);
      send_req(24'd300000);
      send_req(24'd1194000);  // tie between two feedback dividers
      send_req(24'd606000);
    end
    stop_sending();
  endtask

  task automatic test_random_requests();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) set_pll_config(16'hFFFF, 65535 * 255 + 1, 24'hFFFFFF, $urandom_range(1, 0));
      else pick_random_setting();
      idle_en = (phase != 2);
      repeat (20) send_req(random_req());
    end
    stop_sending();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    set_pll_config(12000, 1200000, 1200000, 1);
    idle_en = 1'b0;
    rx_hold = HOLD_CYCLES;
    repeat (5) send_req(random_req());
    stop_sending();
    wait_drained();
    idle_en = 1'b1;
    repeat (3) send_req(random_req());
    stop_sending();
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel_i     = 1'b0;
    penable_i  = 1'b0;
    pwrite_i   = 1'b0;
    paddr_i    = '0;
    pwdata_i   = '0;
    in_valid_i = 1'b0;
    req_khz_i  = '0;
    rx_hold    = 0;
    idle_en    = 1'b1;
    model_cfg.ref_khz        = REF_W'(12000);
    model_cfg.vco_min_khz    = FREQ_W'(400000);
    model_cfg.vco_max_khz    = FREQ_W'(1600000);
    model_cfg.prefer_low_vco = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_masking();
    test_request_extremes();
    test_empty_window();
    test_zero_reference();
    test_search_direction();
    test_backpressure();
    test_random_requests();

    stop_sending();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d of %0d requests over %0d register settings, both search directions.",
             n_checked, n_sent, n_settings);
    $display("%0d results had a setting in range, %0d exact; %0d mismatches.",
             n_found, n_exact, n_errors);
    if (n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
